// ===== sv/aggregate_channel_demux_macros.svh =====
// assertion helpers for the aggregate channel demux
`ifndef AGGREGATE_CHANNEL_DEMUX_MACROS_SVH
`define AGGREGATE_CHANNEL_DEMUX_MACROS_SVH

`ifndef SYNTHESIS

`define CAD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cad assertion failed");

`define CAD_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("cad forbidden condition seen");

`else

`define CAD_ASSERT(lbl, clk, rst, prop)

`define CAD_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== sv/cad_pkg.sv =====
package cad_pkg;

   localparam int CHANNEL_GROUPS = 8;
   localparam int WORD_W = 32;
   localparam int SIZE_W = 31;
   localparam int MASK_W = 8;
   localparam int CH_W = 3;

   localparam logic [3:0] HEADER_TAG = 4'hA;

   localparam logic [MASK_W-1:0] GROUP_MASK = (CHANNEL_GROUPS >= MASK_W) ?
      {MASK_W{1'b1}} : MASK_W'((1 << CHANNEL_GROUPS) - 1);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_BOARD,
      PH_COUNTER,
      PH_TIMETAG,
      PH_SIZE,
      PH_BODY
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] data_word;
      logic [CH_W-1:0]   channel;
      logic              block_first;
      logic              block_last;
      logic              aggregate_end;
      logic              format_error;
   } result_type;

   typedef struct packed {
      logic      error_latched;
      phase_type phase;
   } status_type;

   function automatic logic [CH_W-1:0] lowest_channel(input logic [MASK_W-1:0] m);
      logic [CH_W-1:0] ch;
      ch = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            ch = CH_W'(i);
         end
      end
      return ch;
   endfunction

endpackage

// ===== sv/aggregate_channel_demux.sv =====
// aggregate channel demux
// req channel: one raw readout word per handshake (req_valid / req_ready).
// rsp channel: one tagged block word per handshake (rsp_valid / rsp_ready),
// carrying the channel index and block first / block last / aggregate end
// marks; a malformed header or a zero block size yields a single word with
// rsp_format_error set, after which every incoming word is swallowed.
// header, board, counter and time tag words are consumed with no output.
// a word accepted into the input register passes through the parse logic
// into the output register, from which rsp offers it to the receiver.
// throughput: one word per cycle while rsp_ready stays high; the parse
// state advances once per word as it moves out of the input register.
// when the receiver stalls, the output register holds its word and the
// input register fills; req_ready drops only while both are occupied and
// the held input word would produce an output.
// reset (synchronous, active high) empties both registers, returns the
// parser to waiting for an aggregate header and clears the error flag.
`include "aggregate_channel_demux_macros.svh"

module aggregate_channel_demux (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [cad_pkg::WORD_W-1:0] req_stream_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [cad_pkg::WORD_W-1:0] rsp_data_word,
   output logic [cad_pkg::CH_W-1:0]   rsp_channel,
   output logic                       rsp_block_first,
   output logic                       rsp_block_last,
   output logic                       rsp_aggregate_end,
   output logic                       rsp_format_error
);

   logic                       in_valid_ff, in_valid_in;
   logic [cad_pkg::WORD_W-1:0] in_word_ff;
   logic                       out_valid_ff, out_valid_in;
   cad_pkg::result_type        out_ff;
   cad_pkg::result_type        result;
   cad_pkg::status_type        status;
   logic                       advance;
   logic                       load_out;

   cad_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (in_word_ff),
      .result (result),
      .status (status)
   );

   assign advance   = in_valid_ff && (!result.valid || !out_valid_ff || rsp_ready);
   assign load_out  = advance && result.valid;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_stream_word;
      end
      if (load_out) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_data_word     = out_ff.data_word;
   assign rsp_channel       = out_ff.channel;
   assign rsp_block_first   = out_ff.block_first;
   assign rsp_block_last    = out_ff.block_last;
   assign rsp_aggregate_end = out_ff.aggregate_end;
   assign rsp_format_error  = out_ff.format_error;

   `CAD_ASSERT(a_err_no_marks, clock, reset,
      rsp_valid && rsp_format_error |-> !rsp_block_first && !rsp_block_last && !rsp_aggregate_end)
   `CAD_ASSERT(a_aend_is_last, clock, reset,
      rsp_valid && rsp_aggregate_end |-> rsp_block_last)
   `CAD_ASSERT(a_silent_after_err, clock, reset,
      rsp_valid && rsp_ready && rsp_format_error |=> !rsp_valid && status.error_latched)
   `CAD_ASSERT_NEVER(a_stall_only_on_output, clock, reset,
      in_valid_ff && !req_ready && !(out_valid_ff && !rsp_ready))

endmodule

// ===== sv/cad_parser.sv =====
module cad_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [cad_pkg::WORD_W-1:0] word,
   output cad_pkg::result_type        result,
   output cad_pkg::status_type        status
);

   cad_pkg::phase_type              phase_ff, phase_in;
   logic [cad_pkg::MASK_W-1:0]      mask_ff, mask_in;
   logic [cad_pkg::CH_W-1:0]        channel_ff, channel_in;
   logic [cad_pkg::SIZE_W-1:0]      left_ff, left_in;
   logic                            error_ff, error_in;

   logic [cad_pkg::SIZE_W-1:0]      size;
   logic [cad_pkg::SIZE_W-1:0]      left_dec;
   logic [cad_pkg::MASK_W-1:0]      mask_after;
   logic                            header_ok;

   assign size       = word[cad_pkg::SIZE_W-1:0];
   assign left_dec   = left_ff - cad_pkg::SIZE_W'(1);
   assign mask_after = mask_ff & ~(cad_pkg::MASK_W'(1) << channel_ff);
   assign header_ok  = (word[cad_pkg::WORD_W-1 -: 4] == cad_pkg::HEADER_TAG);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      mask_in    = mask_ff;
      channel_in = channel_ff;
      left_in    = left_ff;
      error_in   = error_ff;
      if (!error_ff) begin
         case (phase_ff)
            cad_pkg::PH_HEADER: begin
               if (!header_ok) begin
                  error_in = 1'b1;
               end else begin
                  phase_in = cad_pkg::PH_BOARD;
               end
            end
            cad_pkg::PH_BOARD: begin
               mask_in  = word[cad_pkg::MASK_W-1:0] & cad_pkg::GROUP_MASK;
               phase_in = cad_pkg::PH_COUNTER;
            end
            cad_pkg::PH_COUNTER: begin
               phase_in = cad_pkg::PH_TIMETAG;
            end
            cad_pkg::PH_TIMETAG: begin
               if (mask_ff == '0) begin
                  phase_in = cad_pkg::PH_HEADER;
               end else begin
                  channel_in = cad_pkg::lowest_channel(mask_ff);
                  phase_in   = cad_pkg::PH_SIZE;
               end
            end
            cad_pkg::PH_SIZE: begin
               if (size == '0) begin
                  error_in = 1'b1;
               end else if (size == cad_pkg::SIZE_W'(1)) begin
                  mask_in = mask_after;
                  left_in = '0;
                  if (mask_after == '0) begin
                     phase_in = cad_pkg::PH_HEADER;
                  end else begin
                     channel_in = cad_pkg::lowest_channel(mask_after);
                     phase_in   = cad_pkg::PH_SIZE;
                  end
               end else begin
                  left_in  = size - cad_pkg::SIZE_W'(1);
                  phase_in = cad_pkg::PH_BODY;
               end
            end
            cad_pkg::PH_BODY: begin
               left_in = left_dec;
               if (left_dec == '0) begin
                  mask_in = mask_after;
                  if (mask_after == '0) begin
                     phase_in = cad_pkg::PH_HEADER;
                  end else begin
                     channel_in = cad_pkg::lowest_channel(mask_after);
                     phase_in   = cad_pkg::PH_SIZE;
                  end
               end
            end
            default: begin
               phase_in = cad_pkg::PH_HEADER;
            end
         endcase
      end
   end

   // result for the current word
   always_comb begin
      result           = '0;
      result.data_word = word;
      result.channel   = channel_ff;
      if (!error_ff) begin
         case (phase_ff)
            cad_pkg::PH_HEADER: begin
               result.valid        = !header_ok;
               result.channel      = '0;
               result.format_error = 1'b1;
            end
            cad_pkg::PH_SIZE: begin
               result.valid = 1'b1;
               if (size == '0) begin
                  result.format_error = 1'b1;
               end else begin
                  result.block_first = 1'b1;
                  if (size == cad_pkg::SIZE_W'(1)) begin
                     result.block_last    = 1'b1;
                     result.aggregate_end = (mask_after == '0);
                  end
               end
            end
            cad_pkg::PH_BODY: begin
               result.valid = 1'b1;
               if (left_dec == '0) begin
                  result.block_last    = 1'b1;
                  result.aggregate_end = (mask_after == '0);
               end
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= cad_pkg::PH_HEADER;
         mask_ff    <= '0;
         channel_ff <= '0;
         left_ff    <= '0;
         error_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         mask_ff    <= mask_in;
         channel_ff <= channel_in;
         left_ff    <= left_in;
         error_ff   <= error_in;
      end
   end

   assign status.error_latched = error_ff;
   assign status.phase         = phase_ff;

endmodule

// ===== tb/tb_aggregate_channel_demux.sv =====
module tb_aggregate_channel_demux;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [cad_pkg::WORD_W-1:0] data_word;
      logic [cad_pkg::CH_W-1:0]   channel;
      logic                       block_first;
      logic                       block_last;
      logic                       aggregate_end;
      logic                       format_error;
   } demux_word_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [cad_pkg::WORD_W-1:0] req_stream_word;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [cad_pkg::WORD_W-1:0] rsp_data_word;
   logic [cad_pkg::CH_W-1:0]   rsp_channel;
   logic                       rsp_block_first;
   logic                       rsp_block_last;
   logic                       rsp_aggregate_end;
   logic                       rsp_format_error;

   logic [cad_pkg::WORD_W-1:0] stream_q[$];
   demux_word_type             expected_words[$];

   // parser state as predicted
   cad_pkg::phase_type         pred_phase;
   logic [cad_pkg::MASK_W-1:0] pred_mask;
   logic [cad_pkg::CH_W-1:0]   pred_channel;
   logic [cad_pkg::SIZE_W-1:0] pred_left;
   bit                         pred_error;

   int                         sent_count;
   int                         total_words;
   int                         checked_count;
   int                         error_count;
   int                         aggregate_count;
   int                         send_gap;
   int                         stall_left;
   bit                         zero_size_tail;

   aggregate_channel_demux dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_stream_word   (req_stream_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_word     (rsp_data_word),
      .rsp_channel       (rsp_channel),
      .rsp_block_first   (rsp_block_first),
      .rsp_block_last    (rsp_block_last),
      .rsp_aggregate_end (rsp_aggregate_end),
      .rsp_format_error  (rsp_format_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [cad_pkg::CH_W-1:0] first_set_bit(
      input logic [cad_pkg::MASK_W-1:0] m);
      for (int i = 0; i < cad_pkg::MASK_W; i++) begin
         if (m[i]) begin
            return cad_pkg::CH_W'(i);
         end
      end
      return '0;
   endfunction

   function automatic demux_word_type make_word(input logic [cad_pkg::WORD_W-1:0] w,
                                                input logic [cad_pkg::CH_W-1:0] ch,
                                                input logic first, input logic last,
                                                input logic aend, input logic ferr);
      demux_word_type d;
      d.data_word = w;
      d.channel = ch;
      d.block_first = first;
      d.block_last = last;
      d.aggregate_end = aend;
      d.format_error = ferr;
      return d;
   endfunction

   // ends the current block, returns 1 when the aggregate is complete
   function automatic logic finish_block();
      pred_mask[pred_channel] = 1'b0;
      pred_left = '0;
      if (pred_mask == '0) begin
         pred_phase = cad_pkg::PH_HEADER;
         return 1'b1;
      end
      pred_channel = first_set_bit(pred_mask);
      pred_phase = cad_pkg::PH_SIZE;
      return 1'b0;
   endfunction

   task automatic parse_stream_word(input logic [cad_pkg::WORD_W-1:0] w);
      logic [cad_pkg::SIZE_W-1:0] size;
      logic [cad_pkg::CH_W-1:0]   ch;
      logic                       aend;
      if (pred_error) begin
         return;
      end
      case (pred_phase)
         cad_pkg::PH_HEADER: begin
            if (w[31:28] != cad_pkg::HEADER_TAG) begin
               pred_error = 1'b1;
               expected_words.push_back(make_word(w, '0, 1'b0, 1'b0, 1'b0, 1'b1));
            end else begin
               pred_phase = cad_pkg::PH_BOARD;
            end
         end
         cad_pkg::PH_BOARD: begin
            pred_mask = w[cad_pkg::MASK_W-1:0] & cad_pkg::GROUP_MASK;
            pred_phase = cad_pkg::PH_COUNTER;
         end
         cad_pkg::PH_COUNTER: begin
            pred_phase = cad_pkg::PH_TIMETAG;
         end
         cad_pkg::PH_TIMETAG: begin
            if (pred_mask == '0) begin
               pred_phase = cad_pkg::PH_HEADER;
            end else begin
               pred_channel = first_set_bit(pred_mask);
               pred_phase = cad_pkg::PH_SIZE;
            end
         end
         cad_pkg::PH_SIZE: begin
            size = w[cad_pkg::SIZE_W-1:0];
            ch = pred_channel;
            if (size == '0) begin
               pred_error = 1'b1;
               expected_words.push_back(make_word(w, ch, 1'b0, 1'b0, 1'b0, 1'b1));
            end else if (size == cad_pkg::SIZE_W'(1)) begin
               aend = finish_block();
               expected_words.push_back(make_word(w, ch, 1'b1, 1'b1, aend, 1'b0));
            end else begin
               pred_left = size - cad_pkg::SIZE_W'(1);
               pred_phase = cad_pkg::PH_BODY;
               expected_words.push_back(make_word(w, ch, 1'b1, 1'b0, 1'b0, 1'b0));
            end
         end
         cad_pkg::PH_BODY: begin
            ch = pred_channel;
            pred_left = pred_left - cad_pkg::SIZE_W'(1);
            if (pred_left == '0) begin
               aend = finish_block();
               expected_words.push_back(make_word(w, ch, 1'b0, 1'b1, aend, 1'b0));
            end else begin
               expected_words.push_back(make_word(w, ch, 1'b0, 1'b0, 1'b0, 1'b0));
            end
         end
         default: begin
            pred_phase = cad_pkg::PH_HEADER;
         end
      endcase
   endtask

   // header, board, counter, time tag, then one block per mask bit
   task automatic add_aggregate(input logic [cad_pkg::WORD_W-1:0] header,
                                input logic [cad_pkg::WORD_W-1:0] board,
                                input int min_len, input int max_len);
      logic [cad_pkg::MASK_W-1:0] mask;
      int len;
      mask = board[cad_pkg::MASK_W-1:0] & cad_pkg::GROUP_MASK;
      stream_q.push_back(header);
      stream_q.push_back(board);
      stream_q.push_back($urandom);
      stream_q.push_back($urandom);
      for (int ch = 0; ch < cad_pkg::MASK_W; ch++) begin
         if (mask[ch]) begin
            len = $urandom_range(max_len, min_len);
            stream_q.push_back({1'($urandom), cad_pkg::SIZE_W'(len)});
            for (int k = 1; k < len; k++) begin
               stream_q.push_back($urandom);
            end
         end
      end
      aggregate_count++;
   endtask

   function automatic logic [cad_pkg::WORD_W-1:0] good_header();
      return {cad_pkg::HEADER_TAG, 28'($urandom)};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && req_ready) begin
            parse_stream_word(req_stream_word);
            sent_count <= sent_count + 1;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (stream_q.size() > 0) begin
               req_valid <= 1'b1;
               req_stream_word <= stream_q.pop_front();
               if (sent_count + 150 < total_words && $urandom_range(9, 0) == 0) begin
                  send_gap <= $urandom_range(13, 1);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      demux_word_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected word: data_word %h channel %0d", rsp_data_word,
                      rsp_channel);
               error_count++;
            end else begin
               e = expected_words.pop_front();
               checked_count++;
               if (rsp_data_word !== e.data_word) begin
                  $error("data_word: expected %h, got %h", e.data_word, rsp_data_word);
                  error_count++;
               end
               if (rsp_channel !== e.channel) begin
                  $error("channel: expected %0d, got %0d", e.channel, rsp_channel);
                  error_count++;
               end
               if (rsp_block_first !== e.block_first) begin
                  $error("block_first: expected %b, got %b", e.block_first,
                         rsp_block_first);
                  error_count++;
               end
               if (rsp_block_last !== e.block_last) begin
                  $error("block_last: expected %b, got %b", e.block_last, rsp_block_last);
                  error_count++;
               end
               if (rsp_aggregate_end !== e.aggregate_end) begin
                  $error("aggregate_end: expected %b, got %b", e.aggregate_end,
                         rsp_aggregate_end);
                  error_count++;
               end
               if (rsp_format_error !== e.format_error) begin
                  $error("format_error: expected %b, got %b", e.format_error,
                         rsp_format_error);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (sent_count + 150 < total_words && $urandom_range(9, 0) == 0) begin
            rsp_ready <= 1'b0;
            stall_left <= $urandom_range(13, 1) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d words sent, %0d results pending", sent_count,
               expected_words.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [3:0] nibble;
      logic [cad_pkg::MASK_W-1:0] mask;
      reset = 1'b1;
      req_valid = 1'b0;
      req_stream_word = '0;
      rsp_ready = 1'b0;
      pred_phase = cad_pkg::PH_HEADER;
      pred_mask = '0;
      pred_channel = '0;
      pred_left = '0;
      pred_error = 1'b0;
      sent_count = 0;
      checked_count = 0;
      error_count = 0;
      aggregate_count = 0;
      send_gap = 0;
      stall_left = 0;

      // directed: empty mask, all channels with one-word blocks, top channel only, channel 0 only
      add_aggregate(32'hA000_0000, 32'hFFFF_FF00, 1, 1);
      add_aggregate(32'hAFFF_FFFF, 32'hFFFF_FFFF, 1, 1);
      add_aggregate(good_header(), 32'h0000_0080, 3, 3);
      stream_q.push_back(good_header());
      stream_q.push_back(32'h0000_0001);
      stream_q.push_back(32'h0000_0000);
      stream_q.push_back(32'hFFFF_FFFF);
      stream_q.push_back(32'h8000_0003);
      stream_q.push_back(32'hFFFF_FFFF);
      stream_q.push_back(32'h0000_0000);
      aggregate_count++;

      // random well-formed aggregates
      while (stream_q.size() < 1930) begin
         if ($urandom_range(19, 0) == 0) begin
            add_aggregate(good_header(), $urandom, 1, 40);
         end else if ($urandom_range(9, 0) == 0) begin
            add_aggregate(good_header(), {24'($urandom), 8'h00}, 1, 1);
         end else begin
            add_aggregate(good_header(), $urandom, 1, 6);
         end
      end

      // exactly one error is injected per run: bad header nibble or zero block size
      zero_size_tail = 1'($urandom);
      if (zero_size_tail) begin
         do begin
            mask = 8'($urandom);
         end while ((mask & cad_pkg::GROUP_MASK) == '0);
         stream_q.push_back(good_header());
         stream_q.push_back({24'($urandom), mask});
         stream_q.push_back($urandom);
         stream_q.push_back($urandom);
         stream_q.push_back({1'($urandom), {cad_pkg::SIZE_W{1'b0}}});
      end else begin
         do begin
            nibble = 4'($urandom);
         end while (nibble == cad_pkg::HEADER_TAG);
         stream_q.push_back({nibble, 28'($urandom)});
      end
      // ignored after the error
      stream_q.push_back(good_header());
      for (int k = 0; k < 8; k++) begin
         stream_q.push_back($urandom);
      end
      total_words = stream_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (stream_q.size() != 0 || req_valid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d words in %0d aggregates sent, %0d tagged words checked",
               sent_count, aggregate_count, checked_count);
      $display("run ended on a %s error", zero_size_tail ? "zero block size" :
               "bad header");
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
